>>> rtl/core/spswd_pkg.sv
`default_nettype none

package spswd_pkg;

  localparam int unsigned FieldW = 24;
  localparam int unsigned TimeW  = 25;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_SWEEP_LIMIT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_PULSE_LIMIT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_LOW_LIMIT   = 2'd2;

  localparam logic [FieldW-1:0] SWEEP_LIMIT_RST = 24'd600;
  localparam logic [FieldW-1:0] PULSE_LIMIT_RST = 24'd2000;
  localparam logic [FieldW-1:0] LOW_LIMIT_RST   = 24'd200000;

  localparam logic [FieldW-1:0] PULSE_BASE = 24'd616;

  // (w - base) / 112 = ((w - base) >> 4) / 7; 20-bit quotient by 7 via reciprocal
  localparam int unsigned Div7InW  = FieldW - 4;
  localparam int unsigned Div7Sh   = Div7InW + 3;
  localparam int unsigned Div7MulW = Div7InW + 1;
  localparam logic [Div7MulW-1:0] DIV7_MUL = 21'd1198373;

  localparam logic OP_LOW  = 1'b0;
  localparam logic OP_HIGH = 1'b1;

  typedef struct packed {
    logic low_drop;
    logic sweep;
    logic sync;
    logic sync_axis;
  } cls_t;

  function automatic logic axis_of(input logic [FieldW-1:0] w);
    logic [FieldW-1:0]              diff;
    logic [Div7InW-1:0]             d;
    logic [Div7InW+Div7MulW-1:0]    prod;
    logic [Div7InW+Div7MulW-1:0]    q;
    diff = w - PULSE_BASE;
    d    = diff[FieldW-1:4];
    prod = (Div7InW+Div7MulW)'(d) * (Div7InW+Div7MulW)'(DIV7_MUL);
    q    = prod >> Div7Sh;
    if (w < PULSE_BASE) begin
      return 1'b0;
    end
    return q[0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/spswd_class.sv
`default_nettype none

module spswd_class
  import spswd_pkg::*;
(
  input  wire logic              op_i,
  input  wire logic [FieldW-1:0] width_i,
  input  wire logic [FieldW-1:0] sweep_limit_i,
  input  wire logic [FieldW-1:0] pulse_limit_i,
  input  wire logic [FieldW-1:0] low_limit_i,
  output cls_t                   cls_o
);

  always_comb begin
    cls_o           = '0;
    cls_o.sync_axis = axis_of(width_i);
    if (op_i == OP_LOW) begin
      cls_o.low_drop = (width_i > low_limit_i);
    end else begin
      cls_o.sweep = (width_i < sweep_limit_i);
      cls_o.sync  = !cls_o.sweep && (width_i < pulse_limit_i);
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sync_pulse_sweep_decoder.sv
`default_nettype none

// Channel   Dir  tdata                     tuser
// s_axis    in   [23:0] pulse_width        [0] op (0 low, 1 high)
// m_axis    out  [24:0] sweep_time, pad 0  [0] scan_axis (0 x, 1 y)
// cfg       in   cfg_idx_i / cfg_data_i written when cfg_we_i
//
// One item per cycle sustained while m_axis is not stalled; an item is captured
// in the input register at acceptance, and a sweep result, when the item yields
// one, is loaded into the result register when the processing stage advances.
// Reset restores the default limits, idle mode and zero stored widths.
// An output stall holds the processing stage; s_axis_tready then drops once
// the input register is occupied.

module sync_pulse_sweep_decoder
  import spswd_pkg::*;
#(
  parameter int unsigned WIDTH_BITS = 24
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [FieldW-1:0]  s_axis_tdata,   // [23:0] pulse_width
  input  wire logic               s_axis_tuser,   // [0] op
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [31:0]             m_axis_tdata,   // [24:0] sweep_time, [31:25] zero
  output logic                    m_axis_tuser,   // [0] scan_axis
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [FieldW-1:0]  cfg_data_i
);

  localparam int unsigned SW = (WIDTH_BITS < FieldW) ? WIDTH_BITS : FieldW;
  localparam logic [FieldW-1:0] WMAX = FieldW'((64'd1 << SW) - 64'd1);

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_X    = 2'd1;
  localparam logic [1:0] MODE_Y    = 2'd2;

  logic [FieldW-1:0] sweep_limit_q, pulse_limit_q, low_limit_q;

  logic              in_valid_q;
  logic              op_q;
  logic [SW-1:0]     width_q;
  logic [FieldW-1:0] sat_w;

  logic [1:0]        mode_q, mode_d;
  logic [SW-1:0]     low_width_q, low_width_d;
  logic [SW-1:0]     sync_width_q, sync_width_d;

  logic              out_valid_q;
  logic              out_axis_q;
  logic [TimeW-1:0]  out_time_q;

  logic              in_go, proc_go, emit;
  cls_t              cls;

  assign sat_w   = (s_axis_tdata > WMAX) ? WMAX : s_axis_tdata;
  assign proc_go = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || proc_go;
  assign in_go   = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_limit_q <= SWEEP_LIMIT_RST;
      pulse_limit_q <= PULSE_LIMIT_RST;
      low_limit_q   <= LOW_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SWEEP_LIMIT: sweep_limit_q <= cfg_data_i;
        CFG_PULSE_LIMIT: pulse_limit_q <= cfg_data_i;
        CFG_LOW_LIMIT:   low_limit_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_go) begin
      in_valid_q <= 1'b1;
    end else if (proc_go) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_go) begin
      op_q    <= s_axis_tuser;
      width_q <= sat_w[SW-1:0];
    end
  end

  spswd_class u_class (
    .op_i          (op_q),
    .width_i       (FieldW'(width_q)),
    .sweep_limit_i (sweep_limit_q),
    .pulse_limit_i (pulse_limit_q),
    .low_limit_i   (low_limit_q),
    .cls_o         (cls)
  );

  always_comb begin
    mode_d       = mode_q;
    low_width_d  = low_width_q;
    sync_width_d = sync_width_q;
    emit         = 1'b0;
    if (op_q == OP_LOW) begin
      if (cls.low_drop) begin
        mode_d      = MODE_IDLE;
        low_width_d = '0;
      end else begin
        low_width_d = width_q;
      end
    end else if (cls.sweep) begin
      if (mode_q != MODE_IDLE) begin
        emit   = 1'b1;
        mode_d = MODE_IDLE;
      end
    end else if (cls.sync) begin
      sync_width_d = width_q;
      mode_d       = cls.sync_axis ? MODE_Y : MODE_X;
    end else begin
      mode_d = MODE_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_IDLE;
      low_width_q  <= '0;
      sync_width_q <= '0;
    end else if (proc_go) begin
      mode_q       <= mode_d;
      low_width_q  <= low_width_d;
      sync_width_q <= sync_width_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc_go) begin
      out_valid_q <= emit;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_go && emit) begin
      out_axis_q <= (mode_q != MODE_X);
      out_time_q <= TimeW'({1'b0, low_width_q} + {1'b0, sync_width_q});
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_axis_q;
  assign m_axis_tdata  = 32'(out_time_q);

  a_emit_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_go && emit |=> mode_q == MODE_IDLE)
    else $error("mode not idle after a sweep result");

  a_long_low_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_go && op_q == OP_LOW && cls.low_drop |=> low_width_q == '0 && mode_q == MODE_IDLE)
    else $error("long low interval did not clear state");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(proc_go && emit))
    else $error("result raised without a sweep hit");

endmodule

`default_nettype wire
